>>> sv/cdras_pkg.sv
`timescale 1ns / 1ps

package cdras_pkg;

   // request kinds carried on req_tuser
   localparam logic [2:0] OP_HEADER = 3'd0;
   localparam logic [2:0] OP_BYTE   = 3'd1;
   localparam logic [2:0] OP_BOOL   = 3'd2;
   localparam logic [2:0] OP_U16    = 3'd3;
   localparam logic [2:0] OP_I32    = 3'd4;
   localparam logic [2:0] OP_I64    = 3'd5;
   localparam logic [2:0] OP_STRING = 3'd6;
   localparam logic [2:0] OP_CHAR   = 3'd7;

   localparam logic [2:0] PHASE_RESET = 3'd4;

   localparam logic [7:0] HEADER_BYTES [4] = '{8'h00, 8'h01, 8'h00, 8'h00};

   // microprogram addresses
   localparam int         UPC_BITS      = 4;
   localparam logic [3:0] UA_HEADER     = 4'd0;
   localparam logic [3:0] UA_BYTE       = 4'd1;
   localparam logic [3:0] UA_BOOL       = 4'd2;
   localparam logic [3:0] UA_U16_PAD    = 4'd3;
   localparam logic [3:0] UA_U16_VAL    = 4'd4;
   localparam logic [3:0] UA_I32_PAD    = 4'd5;
   localparam logic [3:0] UA_I32_VAL    = 4'd6;
   localparam logic [3:0] UA_I64_PAD    = 4'd7;
   localparam logic [3:0] UA_I64_VAL    = 4'd8;
   localparam logic [3:0] UA_STR_PAD    = 4'd9;
   localparam logic [3:0] UA_STR_LEN    = 4'd10;
   localparam logic [3:0] UA_NUL        = 4'd11;
   localparam logic [3:0] UA_CHAR       = 4'd12;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_HDR,
      SEL_VAL
   } sel_type;

   typedef enum logic [1:0] {
      BR_END,    // item finished after this step
      BR_NEXT,   // fall through to the next step
      BR_NUL     // go emit the terminator when one is pending, else finish
   } br_type;

   typedef struct packed {
      sel_type    sel;
      logic [1:0] size_log;
      logic       pad;
      br_type     br;
   } uword_type;

   typedef struct packed {
      logic       emit;
      sel_type    sel;
      logic [2:0] byte_idx;
      logic       last;
      logic [2:0] mask;
      logic       first_val;
   } ctrl_type;

   function automatic uword_type ucode_rom(input logic [3:0] addr);
      uword_type w;
      w = '{sel: SEL_ZERO, size_log: 2'd0, pad: 1'b0, br: BR_END};
      unique case (addr)
         UA_HEADER:  w = '{sel: SEL_HDR,  size_log: 2'd2, pad: 1'b0, br: BR_END};
         UA_BYTE:    w = '{sel: SEL_VAL,  size_log: 2'd0, pad: 1'b0, br: BR_END};
         UA_BOOL:    w = '{sel: SEL_VAL,  size_log: 2'd0, pad: 1'b0, br: BR_END};
         UA_U16_PAD: w = '{sel: SEL_ZERO, size_log: 2'd1, pad: 1'b1, br: BR_NEXT};
         UA_U16_VAL: w = '{sel: SEL_VAL,  size_log: 2'd1, pad: 1'b0, br: BR_END};
         UA_I32_PAD: w = '{sel: SEL_ZERO, size_log: 2'd2, pad: 1'b1, br: BR_NEXT};
         UA_I32_VAL: w = '{sel: SEL_VAL,  size_log: 2'd2, pad: 1'b0, br: BR_END};
         UA_I64_PAD: w = '{sel: SEL_ZERO, size_log: 2'd3, pad: 1'b1, br: BR_NEXT};
         UA_I64_VAL: w = '{sel: SEL_VAL,  size_log: 2'd3, pad: 1'b0, br: BR_END};
         UA_STR_PAD: w = '{sel: SEL_ZERO, size_log: 2'd2, pad: 1'b1, br: BR_NEXT};
         UA_STR_LEN: w = '{sel: SEL_VAL,  size_log: 2'd2, pad: 1'b0, br: BR_NUL};
         UA_NUL:     w = '{sel: SEL_ZERO, size_log: 2'd0, pad: 1'b0, br: BR_END};
         UA_CHAR:    w = '{sel: SEL_VAL,  size_log: 2'd0, pad: 1'b0, br: BR_NUL};
         default:    w = '{sel: SEL_ZERO, size_log: 2'd0, pad: 1'b0, br: BR_END};
      endcase
      return w;
   endfunction

   function automatic logic [3:0] entry_addr(input logic [2:0] op);
      logic [3:0] a;
      a = UA_BYTE;
      unique case (op)
         OP_HEADER: a = UA_HEADER;
         OP_BYTE:   a = UA_BYTE;
         OP_BOOL:   a = UA_BOOL;
         OP_U16:    a = UA_U16_PAD;
         OP_I32:    a = UA_I32_PAD;
         OP_I64:    a = UA_I64_PAD;
         OP_STRING: a = UA_STR_PAD;
         OP_CHAR:   a = UA_CHAR;
         default:   a = UA_BYTE;
      endcase
      return a;
   endfunction

   function automatic logic [2:0] size_mask(input logic [1:0] size_log);
      logic [2:0] m;
      m = 3'd0;
      unique case (size_log)
         2'd0: m = 3'd0;
         2'd1: m = 3'd1;
         2'd2: m = 3'd3;
         2'd3: m = 3'd7;
         default: m = 3'd0;
      endcase
      return m;
   endfunction

endpackage

>>> sv/cdr_aligned_serializer_core.sv
`timescale 1ns / 1ps
// a request holds the sequencer while it emits 1 to 15 bytes, a stalled output holds it
// too, and a 2, 4 or 8 byte value that is already aligned adds a step that emits nothing
// the next request is taken in the cycle after the last byte enters the output register,
// so a new request is not taken while the sequencer is still emitting the last one
// the sequencer registers the request, then its first byte enters the output register
// synchronous active-high reset: position 4, big endian, no string open, outputs empty
module cdr_aligned_serializer_core
   import cdras_pkg::*;
#(
   parameter int LENGTH_BITS = 31
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] value
   input  logic [2:0]  req_tuser,   // [2:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // [0] start_little_endian
);

   localparam logic [LENGTH_BITS-1:0] MAX_LEN = '1;

   logic                   start_le_ff, start_le_in;
   logic                   order_ff, order_in;
   logic [2:0]             phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] chars_ff, chars_in;
   logic                   nul_ff, nul_in;
   logic [63:0]            val_ff, val_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   req_acc;
   logic                   csr_acc;
   logic                   busy;
   logic                   advance;
   logic [LENGTH_BITS-1:0] str_len;
   logic [7:0]             emit_byte;
   ctrl_type               ctrl;

   assign req_acc = req_tvalid && req_tready;
   assign csr_acc = csr_valid && csr_ready;
   assign advance = !rsp_valid_ff || rsp_tready;

   cdras_sequencer u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (req_acc),
      .start_op    (req_tuser),
      .advance     (advance),
      .phase       (phase_ff),
      .little      (order_ff),
      .nul_pending (nul_ff),
      .busy        (busy),
      .ctrl        (ctrl)
   );

   // saturate the string count to the length field
   assign str_len = (|req_tdata[63:LENGTH_BITS]) ? MAX_LEN : req_tdata[LENGTH_BITS-1:0];

   always_comb begin
      unique case (ctrl.sel)
         SEL_ZERO: emit_byte = 8'h00;
         SEL_HDR:  emit_byte = HEADER_BYTES[ctrl.byte_idx[1:0]];
         SEL_VAL:  emit_byte = val_ff[ctrl.byte_idx*8 +: 8];
         default:  emit_byte = 8'h00;
      endcase
   end

   always_comb begin
      start_le_in  = start_le_ff;
      order_in     = order_ff;
      chars_in     = chars_ff;
      nul_in       = nul_ff;
      val_in       = val_ff;
      phase_in     = ctrl.emit ? 3'(phase_ff + 3'd1) : phase_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_acc) begin
         start_le_in = csr_data;
         order_in    = csr_data;
      end

      if (req_acc) begin
         val_in = req_tdata;
         nul_in = 1'b0;
         unique case (req_tuser)
            OP_HEADER: order_in = 1'b1;
            OP_BOOL:   val_in   = {63'd0, |req_tdata};
            OP_STRING: begin
               val_in   = {32'd0, 32'(str_len) + 32'd1};
               chars_in = str_len;
               nul_in   = (str_len == '0);
            end
            OP_CHAR: begin
               if (chars_ff != '0) begin
                  chars_in = chars_ff - LENGTH_BITS'(1);
                  nul_in   = (chars_ff == LENGTH_BITS'(1));
               end
            end
            default: ;
         endcase
      end

      if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_byte;
         rsp_last_in  = ctrl.last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_le_ff  <= 1'b0;
         order_ff     <= 1'b0;
         phase_ff     <= PHASE_RESET;
         chars_ff     <= '0;
         nul_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_le_ff  <= start_le_in;
         order_ff     <= order_in;
         phase_ff     <= phase_in;
         chars_ff     <= chars_in;
         nul_ff       <= nul_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = !busy;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("sequencer not busy after a request");

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("byte emitted over an untaken result");

   a_value_aligned: assert property (@(posedge clock) disable iff (reset)
      (ctrl.emit && ctrl.first_val) |-> ((phase_ff & ctrl.mask) == 3'd0))
      else $error("value starts at a misaligned position");

endmodule

>>> sv/cdras_sequencer.sv
`timescale 1ns / 1ps

module cdras_sequencer
   import cdras_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [2:0] start_op,
   input  logic       advance,
   input  logic [2:0] phase,
   input  logic       little,
   input  logic       nul_pending,
   output logic       busy,
   output ctrl_type   ctrl
);

   logic                busy_ff, busy_in;
   logic [UPC_BITS-1:0] pc_ff, pc_in;
   logic [2:0]          cnt_ff, cnt_in;

   uword_type  uw;
   logic [2:0] mask;
   logic       done;
   logic       misaligned;
   logic       aligned_after;
   logic       take_nul;

   always_comb begin
      uw            = ucode_rom(pc_ff);
      mask          = size_mask(uw.size_log);
      done          = (cnt_ff == mask);
      misaligned    = ((phase & mask) != 3'd0);
      aligned_after = ((3'(phase + 3'd1) & mask) == 3'd0);
      take_nul      = (uw.br == BR_NUL) && nul_pending;
   end

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      cnt_in  = cnt_ff;

      ctrl           = '0;
      ctrl.sel       = uw.sel;
      ctrl.mask      = mask;
      ctrl.first_val = (uw.sel == SEL_VAL) && (cnt_ff == 3'd0);
      if ((uw.sel == SEL_HDR) || little) begin
         ctrl.byte_idx = cnt_ff;
      end else begin
         ctrl.byte_idx = 3'(mask - cnt_ff);
      end

      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = entry_addr(start_op);
            cnt_in  = 3'd0;
         end
      end else if (advance) begin
         if (uw.pad) begin
            // zero fill until the position is a multiple of the value size
            ctrl.emit = misaligned;
            if (!misaligned || aligned_after) begin
               pc_in = pc_ff + UPC_BITS'(1);
            end
         end else begin
            ctrl.emit = 1'b1;
            if (done) begin
               cnt_in = 3'd0;
               unique case (uw.br)
                  BR_NEXT: pc_in = pc_ff + UPC_BITS'(1);
                  BR_NUL: begin
                     if (nul_pending) begin
                        pc_in = UA_NUL;
                     end else begin
                        busy_in = 1'b0;
                     end
                  end
                  BR_END:  busy_in = 1'b0;
                  default: busy_in = 1'b0;
               endcase
               ctrl.last = (uw.br == BR_END) || ((uw.br == BR_NUL) && !take_nul);
            end else begin
               cnt_in = 3'(cnt_ff + 3'd1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign busy = busy_ff;

endmodule

>>> dv/cdr_aligned_serializer_core_tb.sv
`timescale 1ns / 1ps

module cdr_aligned_serializer_core_tb
   import cdras_pkg::*;
();

   localparam int          LEN_BITS       = 31;
   localparam logic [31:0] MAX_COUNT      = (32'd1 << LEN_BITS) - 32'd1;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          SETTLE_CYCLES  = 4;
   localparam int          TAIL_CYCLES    = 20;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          PRINT_LIMIT    = 50;

   localparam logic [7:0] HEADER_PATTERN [4] = '{8'h00, 8'h01, 8'h00, 8'h00};
   localparam logic [2:0] SCALAR_OPS [5] = '{OP_BYTE, OP_BOOL, OP_U16, OP_I32, OP_I64};

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } serial_byte_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_data;

   // serializer state as predicted
   logic [2:0]  phase_mod8;
   logic        little_order;
   logic [31:0] open_chars;

   serial_byte_type expected_bytes[$];
   serial_byte_type item_bytes[$];
   serial_byte_type next_byte;

   int  mismatch_count;
   int  bytes_checked;
   int  quiet_cycles;
   int  hold_cycles;
   bit  sender_idle;
   bit  receiver_idle;

   cdr_aligned_serializer_core #(
      .LENGTH_BITS(LEN_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endtask

   // ---------------------------------------------------------------- predictor

   function automatic void push_byte(input logic [7:0] b);
      serial_byte_type sb;
      sb.data = b;
      sb.last = 1'b0;
      item_bytes.insert(item_bytes.size(), sb);
      phase_mod8 = phase_mod8 + 3'd1;
   endfunction

   // zero pads up to the next multiple of nb, then the value in current order
   function automatic void push_aligned(input logic [63:0] v, input int nb);
      int pad;
      int sh;
      pad = (nb - (int'(phase_mod8) & (nb - 1))) & (nb - 1);
      repeat (pad) push_byte(8'h00);
      for (int i = 0; i < nb; i++) begin
         sh = little_order ? 8 * i : 8 * (nb - 1 - i);
         push_byte(8'(v >> sh));
      end
   endfunction

   function automatic void predict_serial_bytes(input logic [2:0] op, input logic [63:0] v);
      logic [31:0] count;
      item_bytes.delete();
      unique case (op)
         OP_HEADER: begin
            for (int i = 0; i < 4; i++) push_byte(HEADER_PATTERN[i]);
            little_order = 1'b1;
         end
         OP_BYTE:  push_byte(v[7:0]);
         OP_BOOL:  push_byte((v != 64'd0) ? 8'h01 : 8'h00);
         OP_U16:   push_aligned({48'd0, v[15:0]}, 2);
         OP_I32:   push_aligned({32'd0, v[31:0]}, 4);
         OP_I64:   push_aligned(v, 8);
         OP_STRING: begin
            count = (v > 64'(MAX_COUNT)) ? MAX_COUNT : v[31:0];
            push_aligned({32'd0, count + 32'd1}, 4);
            open_chars = count;
            if (count == 32'd0) push_byte(8'h00);
         end
         default: begin
            push_byte(v[7:0]);
            if (open_chars != 32'd0) begin
               open_chars = open_chars - 32'd1;
               // terminator follows the final character
               if (open_chars == 32'd0) push_byte(8'h00);
            end
         end
      endcase
      item_bytes[item_bytes.size() - 1].last = 1'b1;
      foreach (item_bytes[i]) expected_bytes.insert(expected_bytes.size(), item_bytes[i]);
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_request(input logic [2:0] op, input logic [63:0] value);
      int gap;
      @(negedge clock);
      if (sender_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      predict_serial_bytes(op, value);
   endtask

   // stop offering, wait for every expected byte, then let the block go idle
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_start_order(input logic le);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= le;
      do @(posedge clock); while (!csr_ready);
      little_order = le;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] rand_value();
      logic [63:0] v;
      case ($urandom_range(0, 4))
         0:       v = 64'd0;
         1:       v = '1;
         2:       v = 64'($urandom_range(0, 255));
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   task automatic send_scalar();
      send_request(SCALAR_OPS[$urandom_range(0, 4)], rand_value());
   endtask

   // mostly well-formed streams: headers, scalars and strings with their chars
   task automatic run_random_stream(input int n_items);
      int sent;
      int kind;
      int n_chars;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            send_request(OP_HEADER, rand_value());
            sent++;
         end else if (kind <= 3) begin
            n_chars = $urandom_range(0, 5);
            send_request(OP_STRING, 64'(n_chars));
            sent++;
            for (int i = 0; i < n_chars; i++) begin
               if ($urandom_range(0, 4) == 0) begin
                  send_scalar();
                  sent++;
               end
               send_request(OP_CHAR, rand_value());
               sent++;
            end
         end else if (kind <= 7) begin
            send_scalar();
            sent++;
         end else begin
            // noise: any kind with any value, may leave a huge string open
            send_request(3'($urandom_range(0, 7)), rand_value());
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_scalars();
      // first value starts at position 4, so the 8-byte value pads to offset 8
      send_request(OP_I64,  64'h0123_4567_89AB_CDEF);
      send_request(OP_BYTE, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(OP_U16,  64'h0000_0000_0000_FFFF);
      send_request(OP_BOOL, 64'd0);
      send_request(OP_BOOL, 64'h8000_0000_0000_0000);
      send_request(OP_I32,  64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   task automatic test_header_midstream();
      send_request(OP_BYTE,   64'h0000_0000_0000_005A);
      send_request(OP_HEADER, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(OP_I64,    64'hFFFF_FFFF_FFFF_FFFF);
      send_request(OP_I64,    64'd0);
      send_request(OP_U16,    64'h0000_0000_0000_1234);
   endtask

   task automatic test_strings();
      send_request(OP_STRING, 64'd0);
      send_request(OP_STRING, 64'd3);
      send_request(OP_CHAR,   64'h41);
      send_request(OP_U16,    64'hBEEF);
      send_request(OP_CHAR,   64'h42);
      send_request(OP_CHAR,   64'h43);
      // restart after one char drops the open string without its terminator
      send_request(OP_STRING, 64'd5);
      send_request(OP_CHAR,   64'h61);
      send_request(OP_STRING, 64'd1);
      send_request(OP_CHAR,   64'h62);
      send_request(OP_STRING, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(OP_STRING, 64'(MAX_COUNT));
      send_request(OP_STRING, 64'(MAX_COUNT) + 64'd1);
      send_request(OP_STRING, 64'd0);
   endtask

   task automatic test_raw_chars();
      send_request(OP_CHAR, 64'h0000_0000_0000_00A5);
      send_request(OP_CHAR, 64'hFFFF_FFFF_FFFF_FF00);
   endtask

   task automatic test_start_order();
      settle();
      write_start_order(1'b1);
      send_request(OP_I32,  64'h0000_0000_DEAD_BEEF);
      send_request(OP_U16,  64'h0000_0000_0000_C001);
      send_request(OP_I64,  64'h1122_3344_5566_7788);
      settle();
      // write reloads the order at once, even after a header
      send_request(OP_HEADER, 64'd0);
      settle();
      write_start_order(1'b0);
      send_request(OP_I32,  64'h0000_0000_CAFE_F00D);
      send_request(OP_BYTE, 64'h0000_0000_0000_0080);
      settle();
   endtask

   task automatic test_backpressure();
      sender_idle = 1'b0;
      hold_cycles = HOLD_CYCLES;
      for (int i = 0; i < 12; i++) send_request(OP_I64, {$urandom, $urandom});
      settle();
      sender_idle = 1'b1;
   endtask

   task automatic test_random();
      write_start_order(1'b1);
      run_random_stream(22);
      settle();
      write_start_order(1'b0);
      run_random_stream(22);
      settle();
      write_start_order(1'($urandom_range(0, 1)));
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      run_random_stream(22);
      settle();
   endtask

   // ---------------------------------------------------------------- receiver

   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles - 1) @(negedge clock);
            hold_cycles = 0;
         end else if (receiver_idle && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b", rsp_tdata, rsp_tlast));
         end else begin
            next_byte = expected_bytes.pop_front();
            if (rsp_tdata !== next_byte.data) begin
               report_mismatch($sformatf("byte %0d: out_byte %02h, expected %02h",
                                         bytes_checked, rsp_tdata, next_byte.data));
            end
            if (rsp_tlast !== next_byte.last) begin
               report_mismatch($sformatf("byte %0d: last_of_item %0b, expected %0b",
                                         bytes_checked, rsp_tlast, next_byte.last));
            end
         end
         bytes_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- main

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = 64'd0;
      req_tuser      = OP_HEADER;
      csr_valid      = 1'b0;
      csr_data       = 1'b0;
      phase_mod8     = 3'd4;
      little_order   = 1'b0;
      open_chars     = 32'd0;
      mismatch_count = 0;
      bytes_checked  = 0;
      quiet_cycles   = 0;
      hold_cycles    = 0;
      sender_idle    = 1'b1;
      receiver_idle  = 1'b1;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_scalars();
      test_header_midstream();
      test_strings();
      test_raw_chars();
      test_start_order();
      test_backpressure();
      test_random();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         report_mismatch($sformatf("%0d expected bytes never came", expected_bytes.size()));
      end

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/cdras_pkg.sv
sv/cdras_sequencer.sv
sv/cdr_aligned_serializer_core.sv
dv/cdr_aligned_serializer_core_tb.sv
